// ===== rtl/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

  // field widths
  localparam int CntW     = 13;
  localparam int RadW     = 16;
  localparam int TexW     = 17;
  localparam int PosW     = 17;
  localparam int NormW    = 16;

  // divider chain: one integer bit then one fraction bit per cell
  localparam int DivSteps = 33;
  localparam int QuoW     = DivSteps + 1;
  localparam int RemW     = 13;

  // cordic datapath, Q2.30 vectors and binary angles
  localparam int CorW     = 32;
  localparam int AngW     = 33;
  localparam logic signed [CorW-1:0] CordicGain = 32'sd652032874;
  localparam logic signed [AngW-1:0] QuarterTurn = 33'sd1073741824;

  // configuration register indexes
  localparam logic [1:0] CfgRadius  = 2'd0;
  localparam logic [1:0] CfgSectors = 2'd1;
  localparam logic [1:0] CfgStacks  = 2'd2;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
  } div_vec_t;

  typedef struct packed {
    logic signed [CorW-1:0] x;
    logic signed [CorW-1:0] y;
    logic signed [AngW-1:0] z;
  } cordic_vec_t;

  // arctan(2^-k) in binary-angle units
  function automatic logic signed [AngW-1:0] atan_turn(input int unsigned k);
    case (k)
      0:       return 33'sd536870912;
      1:       return 33'sd316933406;
      2:       return 33'sd167458907;
      3:       return 33'sd85004756;
      4:       return 33'sd42667331;
      5:       return 33'sd21354465;
      6:       return 33'sd10679838;
      7:       return 33'sd5340245;
      8:       return 33'sd2670163;
      9:       return 33'sd1335087;
      10:      return 33'sd667544;
      11:      return 33'sd333772;
      12:      return 33'sd166886;
      13:      return 33'sd83443;
      14:      return 33'sd41722;
      15:      return 33'sd20861;
      16:      return 33'sd10430;
      17:      return 33'sd5215;
      18:      return 33'sd2608;
      19:      return 33'sd1304;
      20:      return 33'sd652;
      21:      return 33'sd326;
      22:      return 33'sd163;
      23:      return 33'sd81;
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/uvs_div_cell.sv =====
`default_nettype none
module uvs_div_cell (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [uvs_pkg::RemW-1:0]   divisor_i,
  input  wire uvs_pkg::div_vec_t          vec_i,
  output uvs_pkg::div_vec_t               vec_o
);
  import uvs_pkg::*;

  logic [RemW:0]   dbl;
  logic [RemW:0]   diff;
  logic            ge;
  div_vec_t        vec_d;
  div_vec_t        vec_q;

  // one restoring step: double, compare, subtract
  always_comb begin
    dbl        = {vec_i.rem, 1'b0};
    ge         = dbl >= {1'b0, divisor_i};
    diff       = dbl - {1'b0, divisor_i};
    vec_d.rem  = ge ? diff[RemW-1:0] : dbl[RemW-1:0];
    vec_d.quo  = {vec_i.quo[QuoW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule
`default_nettype wire

// ===== rtl/uvs_cordic_cell.sv =====
`default_nettype none
module uvs_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire uvs_pkg::cordic_vec_t vec_i,
  output uvs_pkg::cordic_vec_t      vec_o
);
  import uvs_pkg::*;

  localparam logic signed [AngW-1:0] Atan = atan_turn(STAGE);

  logic signed [CorW-1:0] dx;
  logic signed [CorW-1:0] dy;
  cordic_vec_t            vec_d;
  cordic_vec_t            vec_q;

  // rotate toward zero residual angle, floor shifts
  always_comb begin
    dx = vec_i.y >>> STAGE;
    dy = vec_i.x >>> STAGE;
    if (!vec_i.z[AngW-1]) begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - Atan;
    end else begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule
`default_nettype wire

// ===== rtl/uv_sphere_vertex_generator.sv =====
// throughput: one word per cycle; the whole pipeline moves when the output register is free
// depth is set by the 33-cell bit-serial divider chain and the CORDIC_STAGES rotation chain
// reset clears all valid bits and loads radius 256, 36 sectors, 18 stacks
// configuration writes are taken every cycle
`default_nettype none
module uv_sphere_vertex_generator #(
  parameter int MAX_DIVISIONS = 4096,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [uvs_pkg::RadW-1:0]          cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [uvs_pkg::CntW-1:0]          stack_index_i,
  input  wire logic [uvs_pkg::CntW-1:0]          sector_index_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [uvs_pkg::PosW-1:0]        pos_x_o,
  output logic signed [uvs_pkg::PosW-1:0]        pos_y_o,
  output logic signed [uvs_pkg::PosW-1:0]        pos_z_o,
  output logic signed [uvs_pkg::NormW-1:0]       norm_x_o,
  output logic signed [uvs_pkg::NormW-1:0]       norm_y_o,
  output logic signed [uvs_pkg::NormW-1:0]       norm_z_o,
  output logic [uvs_pkg::TexW-1:0]               tex_u_o,
  output logic [uvs_pkg::TexW-1:0]               tex_v_o
);
  import uvs_pkg::*;

  localparam int MaxCnt  = (MAX_DIVISIONS > 8191) ? 8191 : MAX_DIVISIONS;
  localparam logic [CntW-1:0] MaxC = CntW'(MaxCnt);
  localparam int SaIdx   = DivSteps + 1;
  localparam int NStg    = DivSteps + CORDIC_STAGES + 5;

  typedef struct packed {
    logic            flip;
    logic [TexW-1:0] tex_u;
    logic [TexW-1:0] tex_v;
  } side_t;

  // saturating range helpers
  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [20:0] v);
    if (v > 21'sd65535) return 17'sd65535;
    if (v < -21'sd65535) return -17'sd65535;
    return v[PosW-1:0];
  endfunction

  function automatic logic signed [NormW-1:0] sat_norm(input logic signed [17:0] v);
    if (v > 18'sd16384) return 16'sd16384;
    if (v < -18'sd16384) return -16'sd16384;
    return v[NormW-1:0];
  endfunction

  // configuration registers; the counts are stored already clamped
  logic [RadW-1:0] radius_q;
  logic [CntW-1:0] sectors_q;
  logic [CntW-1:0] stacks_q;
  logic [CntW-1:0] cfg_cnt;

  assign cfg_ready_o = 1'b1;
  assign cfg_cnt     = cfg_data_i[CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 16'd256;
      sectors_q <= 13'd36;
      stacks_q  <= 13'd18;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRadius:  radius_q <= cfg_data_i;
        CfgSectors: sectors_q <= (cfg_cnt < 13'd3) ? 13'd3 :
                                 ((cfg_cnt > MaxC) ? MaxC : cfg_cnt);
        CfgStacks:  stacks_q <= (cfg_cnt < 13'd2) ? 13'd2 :
                                ((cfg_cnt > MaxC) ? MaxC : cfg_cnt);
        default: ;
      endcase
    end
  end

  // global advance and valid chain
  logic            adv;
  logic            in_acc;
  logic [NStg-1:0] pipe_v_q;
  logic            out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_v_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      pipe_v_q    <= {pipe_v_q[NStg-2:0], in_acc};
      out_valid_q <= pipe_v_q[NStg-1];
    end
  end

  assign out_valid_o = out_valid_q;

  // index saturation and integer quotient bit
  div_vec_t        divi_vec [DivSteps+1];
  div_vec_t        divj_vec [DivSteps+1];
  logic [CntW-1:0] sat_i;
  logic [CntW-1:0] sat_j;
  logic            q0_i;
  logic            q0_j;

  always_comb begin
    sat_i = (stack_index_i > stacks_q) ? stacks_q : stack_index_i;
    sat_j = (sector_index_i > sectors_q) ? sectors_q : sector_index_i;
    q0_i  = sat_i == stacks_q;
    q0_j  = sat_j == sectors_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      divi_vec[0].rem <= q0_i ? '0 : sat_i;
      divi_vec[0].quo <= QuoW'(q0_i);
      divj_vec[0].rem <= q0_j ? '0 : sat_j;
      divj_vec[0].quo <= QuoW'(q0_j);
    end
  end

  // divider cell chains, floor(idx * 2^33 / count)
  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    uvs_div_cell u_div_i (
      .clk_i     (clk_i),
      .en_i      (adv),
      .divisor_i (stacks_q),
      .vec_i     (divi_vec[g]),
      .vec_o     (divi_vec[g+1])
    );
    uvs_div_cell u_div_j (
      .clk_i     (clk_i),
      .en_i      (adv),
      .divisor_i (sectors_q),
      .vec_i     (divj_vec[g]),
      .vec_o     (divj_vec[g+1])
    );
  end

  // angle stage: rounding, longitude folding, texture coordinates
  logic [QuoW-1:0] qi;
  logic [QuoW-1:0] qj;
  logic [QuoW-1:0] lat_rnd;
  logic [QuoW:0]   lon_rnd;
  logic [31:0]     lon_u;
  logic            flip_d;
  logic [31:0]     lon_f;
  logic [17:0]     tv_rnd;
  logic [17:0]     tu_rnd;
  logic [AngW-1:0] lat_d;
  logic signed [AngW-1:0] lat_q;
  logic signed [AngW-1:0] lon_q;
  side_t           side_q [CORDIC_STAGES+1];

  always_comb begin
    qi      = divi_vec[DivSteps].quo;
    qj      = divj_vec[DivSteps].quo;
    lat_rnd = {1'b0, qi[QuoW-1:1]} + 34'd1;
    lat_d   = AngW'(QuarterTurn) - lat_rnd[QuoW-1:1];
    lon_rnd = {1'b0, qj} + 35'd1;
    lon_u   = lon_rnd[32:1];
    flip_d  = lon_u[31] ^ lon_u[30];
    lon_f   = flip_d ? {~lon_u[31], lon_u[30:0]} : lon_u;
    tv_rnd  = qi[QuoW-1:16] + 18'd1;
    tu_rnd  = qj[QuoW-1:16] + 18'd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lat_q           <= lat_d;
      lon_q           <= {lon_f[31], lon_f};
      side_q[0].flip  <= flip_d;
      side_q[0].tex_v <= tv_rnd[17:1];
      side_q[0].tex_u <= 17'd65536 - tu_rnd[17:1];
    end
  end

  // cordic cell chains for latitude and longitude
  cordic_vec_t lat_vec [CORDIC_STAGES+1];
  cordic_vec_t lon_vec [CORDIC_STAGES+1];

  assign lat_vec[0] = '{x: CordicGain, y: '0, z: lat_q};
  assign lon_vec[0] = '{x: CordicGain, y: '0, z: lon_q};

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    uvs_cordic_cell #(.STAGE(k)) u_lat (
      .clk_i (clk_i),
      .en_i  (adv),
      .vec_i (lat_vec[k]),
      .vec_o (lat_vec[k+1])
    );
    uvs_cordic_cell #(.STAGE(k)) u_lon (
      .clk_i (clk_i),
      .en_i  (adv),
      .vec_i (lon_vec[k]),
      .vec_o (lon_vec[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // product stage
  logic signed [CorW-1:0] co_s;
  logic signed [CorW-1:0] so_s;
  logic signed [63:0]     px_q;
  logic signed [63:0]     py_q;
  logic signed [CorW-1:0] sl_q;
  side_t                  m1_side_q;

  always_comb begin
    co_s = side_q[CORDIC_STAGES].flip ? -lon_vec[CORDIC_STAGES].x : lon_vec[CORDIC_STAGES].x;
    so_s = side_q[CORDIC_STAGES].flip ? -lon_vec[CORDIC_STAGES].y : lon_vec[CORDIC_STAGES].y;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q      <= lat_vec[CORDIC_STAGES].x * co_s;
      py_q      <= lat_vec[CORDIC_STAGES].x * so_s;
      sl_q      <= lat_vec[CORDIC_STAGES].y;
      m1_side_q <= side_q[CORDIC_STAGES];
    end
  end

  // rounding stage: Q30 products and normals
  logic signed [63:0]     px_r30;
  logic signed [63:0]     py_r30;
  logic signed [63:0]     px_r46;
  logic signed [63:0]     py_r46;
  logic signed [32:0]     sl_r16;
  logic signed [33:0]     pxy_q;
  logic signed [33:0]     pyy_q;
  logic signed [CorW-1:0] sl2_q;
  logic signed [NormW-1:0] nx_q;
  logic signed [NormW-1:0] ny_q;
  logic signed [NormW-1:0] nz_q;
  side_t                  m2_side_q;

  always_comb begin
    px_r30 = px_q + 64'sd536870912;
    py_r30 = py_q + 64'sd536870912;
    px_r46 = px_q + 64'sd35184372088832;
    py_r46 = py_q + 64'sd35184372088832;
    sl_r16 = {sl_q[CorW-1], sl_q} + 33'sd32768;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pxy_q     <= px_r30[63:30];
      pyy_q     <= py_r30[63:30];
      sl2_q     <= sl_q;
      nx_q      <= sat_norm(px_r46[63:46]);
      ny_q      <= sat_norm(py_r46[63:46]);
      nz_q      <= sat_norm({sl_r16[32], sl_r16[32:16]});
      m2_side_q <= m1_side_q;
    end
  end

  // radius scaling stage
  logic signed [RadW:0]   r_s;
  logic signed [50:0]     rx_q;
  logic signed [50:0]     ry_q;
  logic signed [50:0]     rz_q;
  logic signed [NormW-1:0] nx3_q;
  logic signed [NormW-1:0] ny3_q;
  logic signed [NormW-1:0] nz3_q;
  side_t                  m3_side_q;

  assign r_s = {1'b0, radius_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q      <= r_s * pxy_q;
      ry_q      <= r_s * pyy_q;
      rz_q      <= r_s * sl2_q;
      nx3_q     <= nx_q;
      ny3_q     <= ny_q;
      nz3_q     <= nz_q;
      m3_side_q <= m2_side_q;
    end
  end

  // output register: Q8.8 rounding and saturation
  logic signed [50:0] rx_r;
  logic signed [50:0] ry_r;
  logic signed [50:0] rz_r;

  always_comb begin
    rx_r = rx_q + 51'sd536870912;
    ry_r = ry_q + 51'sd536870912;
    rz_r = rz_q + 51'sd536870912;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_o  <= sat_pos(rx_r[50:30]);
      pos_y_o  <= sat_pos(ry_r[50:30]);
      pos_z_o  <= sat_pos(rz_r[50:30]);
      norm_x_o <= nx3_q;
      norm_y_o <= ny3_q;
      norm_z_o <= nz3_q;
      tex_u_o  <= m3_side_q.tex_u;
      tex_v_o  <= m3_side_q.tex_v;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sectors_q >= 13'd3 && stacks_q >= 13'd2 && sectors_q <= MaxC && stacks_q <= MaxC)
    else $error("division count outside clamp range");

  a_lat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_v_q[SaIdx] |-> (lat_q <= QuarterTurn && lat_q >= -QuarterTurn))
    else $error("latitude angle outside quarter turn");

  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tex_u_o <= 17'd65536 && tex_v_o <= 17'd65536))
    else $error("texture coordinate above one");

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (norm_z_o <= 16'sd16384 && norm_z_o >= -16'sd16384))
    else $error("normal z outside unit range");
`endif

endmodule
`default_nettype wire

// ===== bench/uv_sphere_vertex_generator_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_vertex_generator_test;
  import uvs_pkg::*;

  localparam int MaxDiv = 4096;
  localparam int Stages = 16;
  localparam int Latency = 39 + Stages;
  localparam int WatchLimit = 4000;
  localparam int RandomWords = 1300;
  localparam longint Quarter = 64'sd1073741824;
  localparam longint Half = 64'sd2147483648;
  localparam longint Full = 64'sd4294967296;
  // index with no register behind it
  localparam logic [1:0] CfgSpare = 2'd3;

  typedef struct packed {
    logic signed [PosW-1:0] px, py, pz;
    logic signed [NormW-1:0] nx, ny, nz;
    logic [TexW-1:0] u, v;
  } vertex_t;

  // one directed row: inputs plus an optional typed-in vertex
  typedef struct {
    int i, j;
    bit known;
    vertex_t vx;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [RadW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CntW-1:0] stack_index_i = '0;
  logic [CntW-1:0] sector_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [PosW-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [NormW-1:0] norm_x_o, norm_y_o, norm_z_o;
  logic [TexW-1:0] tex_u_o, tex_v_o;

  uv_sphere_vertex_generator dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow registers
  longint radius_q = 256, sectors_q = 36, stacks_q = 18;

  vertex_t pending_vertices[$];
  int fail_count = 0;
  int words_in = 0, words_out = 0, idle_cycles = 0;
  bit calm = 1'b0;     // no idling in the last part
  bit hold_rx = 1'b0;  // long receiver hold-off
  bit timed_out = 1'b0;

  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_units(int k);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[k];
  endfunction

  // rotation-mode cordic over Q2.30
  task automatic rotate(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = 652032874;
    y = 0;
    for (int k = 0; k < Stages && k < 24; k++) begin
      dx = fshift(y, k);
      dy = fshift(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_units(k);
      end else begin
        x += dx; y -= dy; z += atan_units(k);
      end
    end
    c = x;
    s = y;
  endtask

  task automatic predict_vertex(input int si, input int sj, output vertex_t vx);
    longint stk, sec, i, j, lat, lon, lonu, cl, sl, co, so, px, py, pxy, pyy;
    bit flip;
    stk = sat(stacks_q, 2, MaxDiv);
    sec = sat(sectors_q, 3, MaxDiv);
    i = si > stk ? stk : si;
    j = sj > sec ? sec : sj;
    flip = 1'b0;
    lat = Quarter - (((i << 31) + stk / 2) / stk);
    lonu = (((j << 32) + sec / 2) / sec) & 64'hFFFF_FFFF;
    if (lonu >= Quarter && lonu < 3 * Quarter) begin
      lon = lonu - Half;
      flip = 1'b1;
    end else if (lonu >= 3 * Quarter) lon = lonu - Full;
    else lon = lonu;
    rotate(lat, cl, sl);
    rotate(lon, co, so);
    if (flip) begin
      co = -co; so = -so;
    end
    px = cl * co;
    py = cl * so;
    pxy = fshift(px + (64'sd1 << 29), 30);
    pyy = fshift(py + (64'sd1 << 29), 30);
    vx.px = PosW'(sat(fshift(radius_q * pxy + (64'sd1 << 29), 30), -65535, 65535));
    vx.py = PosW'(sat(fshift(radius_q * pyy + (64'sd1 << 29), 30), -65535, 65535));
    vx.pz = PosW'(sat(fshift(radius_q * sl + (64'sd1 << 29), 30), -65535, 65535));
    vx.nx = NormW'(sat(fshift(px + (64'sd1 << 45), 46), -16384, 16384));
    vx.ny = NormW'(sat(fshift(py + (64'sd1 << 45), 46), -16384, 16384));
    vx.nz = NormW'(sat(fshift(sl + (64'sd1 << 15), 16), -16384, 16384));
    vx.u = TexW'(65536 - (((j << 16) + sec / 2) / sec));
    vx.v = TexW'(((i << 16) + stk / 2) / stk);
  endtask

  // sender gap: drop valid only when a gap is taken
  task automatic idle_burst();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // register write, only while idle
  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[RadW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgRadius) radius_q = val & 16'hFFFF;
    else if (idx == CfgSectors) sectors_q = val & 13'h1FFF;
    else if (idx == CfgStacks) stacks_q = val & 13'h1FFF;
  endtask

  task automatic send_word(input int i, input int j, input bit known, input vertex_t given);
    vertex_t vx;
    predict_vertex(i, j, vx);
    if (known && vx !== given) begin
      $error("typed-in vertex for (%0d,%0d) disagrees with prediction", i, j);
      fail_count++;
    end
    in_valid_i <= 1'b1;
    stack_index_i <= i[CntW-1:0];
    sector_index_i <= j[CntW-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    pending_vertices = {pending_vertices, vx};
    words_in++;
    idle_burst();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_vertices.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // bias indices toward edges
  function automatic int pick_index(longint cnt);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return cnt;
      2: return $urandom_range(0, 8191);
      default: return $urandom_range(0, cnt + 1);
    endcase
  endfunction

  // receiver
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rx) out_ready_i <= 1'b0;
      else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else out_ready_i <= 1'b1;
    end
  end

  // pressure: long hold-off while the sender keeps offering
  initial begin
    @(posedge rst_ni);
    wait (words_in >= 400);
    hold_rx = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // vertex checker
  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      words_out++;
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex word");
        fail_count++;
      end else begin
        want = pending_vertices.pop_front();
        if (pos_x_o !== want.px) begin
          $error("pos_x expected %0d got %0d", want.px, pos_x_o); fail_count++;
        end
        if (pos_y_o !== want.py) begin
          $error("pos_y expected %0d got %0d", want.py, pos_y_o); fail_count++;
        end
        if (pos_z_o !== want.pz) begin
          $error("pos_z expected %0d got %0d", want.pz, pos_z_o); fail_count++;
        end
        if (norm_x_o !== want.nx) begin
          $error("norm_x expected %0d got %0d", want.nx, norm_x_o); fail_count++;
        end
        if (norm_y_o !== want.ny) begin
          $error("norm_y expected %0d got %0d", want.ny, norm_y_o); fail_count++;
        end
        if (norm_z_o !== want.nz) begin
          $error("norm_z expected %0d got %0d", want.nz, norm_z_o); fail_count++;
        end
        if (tex_u_o !== want.u) begin
          $error("tex_u expected %0d got %0d", want.u, tex_u_o); fail_count++;
        end
        if (tex_v_o !== want.v) begin
          $error("tex_v expected %0d got %0d", want.v, tex_v_o); fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired with %0d vertices outstanding", pending_vertices.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    int settings[6][3] = '{'{256, 36, 18}, '{65535, 3, 2}, '{1, 4096, 4096},
                           '{0, 8191, 0}, '{40000, 7, 5}, '{65535, 4096, 3}};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under reset settings (radius 1.0, 36 x 18)
    r = '{0, 0, 1'b1, '{0, 0, 256, 0, 0, 16384, 65536, 0}}; rows = {rows, r};
    r = '{18, 0, 1'b1, '{0, 0, -256, 0, 0, -16384, 65536, 65536}}; rows = {rows, r};
    r = '{8191, 8191, 1'b0, '0}; rows = {rows, r};
    r = '{9, 0, 1'b0, '0}; rows = {rows, r};
    r = '{9, 9, 1'b0, '0}; rows = {rows, r};
    r = '{9, 18, 1'b0, '0}; rows = {rows, r};
    r = '{9, 27, 1'b0, '0}; rows = {rows, r};
    r = '{9, 36, 1'b0, '0}; rows = {rows, r};
    r = '{4, 5, 1'b0, '0}; rows = {rows, r};
    r = '{13, 31, 1'b0, '0}; rows = {rows, r};
    r = '{4096, 4096, 1'b0, '0}; rows = {rows, r};
    r = '{1, 8190, 1'b0, '0}; rows = {rows, r};
    r = '{8190, 1, 1'b0, '0}; rows = {rows, r};
    r = '{5461, 2730, 1'b0, '0}; rows = {rows, r};
    foreach (rows[k]) send_word(rows[k].i, rows[k].j, rows[k].known, rows[k].vx);
    drain();

    // zero radius, clamped counts, unused register index
    write_reg(CfgRadius, 0);
    write_reg(CfgSpare, 16'hFFFF);
    write_reg(CfgSectors, 1);
    write_reg(CfgStacks, 1);
    send_word(0, 0, 1'b0, '0);
    send_word(1, 1, 1'b0, '0);
    send_word(2, 2, 1'b0, '0);
    send_word(2, 3, 1'b0, '0);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgRadius, settings[ph][0]);
      write_reg(CfgSectors, settings[ph][1]);
      write_reg(CfgStacks, settings[ph][2]);
      for (int n = 0; n < RandomWords / 6; n++) begin
        if (ph == 5 && n > RandomWords / 12) calm = 1'b1;
        send_word(pick_index(sat(stacks_q, 2, MaxDiv)),
                  pick_index(sat(sectors_q, 3, MaxDiv)), 1'b0, '0);
      end
      drain();
    end

    $display("sent %0d grid points over 8 register settings, %0d vertices checked",
             words_in, words_out);
    $display("radius, division clamps, index saturation and backpressure exercised");
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
